### hdl/ssd_pkg.sv
// Shared types, constants and functions for the seven-segment scan driver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ssd_pkg;

  localparam int DIGITS_DEFAULT = 4;
  localparam int NUMBER_W       = 14;
  localparam int SEG_W          = 7;
  localparam int ENABLE_W       = 4;
  localparam int BCD_W          = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // n / 10 as (n * RECIP_10) >> RECIP_SHIFT, exact for n below 87381
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic                operation;
    logic [NUMBER_W-1:0] number;
  } item_t;

  typedef struct packed {
    logic [SEG_W-1:0]    segments;
    logic [ENABLE_W-1:0] digit_enable;
  } result_t;

  typedef struct packed {
    logic load_start;
    logic tick;
    logic split_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic split_last;
  } ctrl_status_t;

  function automatic logic [31:0] max_value(input int digits);
    logic [31:0] v;
    v = 32'd1;
    for (int i = 0; i < digits; i++) begin
      v = v * 32'd10;
    end
    return v - 32'd1;
  endfunction

  function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

### hdl/ssd_controller.sv
// Sequencing state machine: accepts words, steps the digit split, issues
// the result write. Depends on ssd_pkg.
`timescale 1ns / 1ps
module ssd_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  operation,
  output logic                  result_valid,
  input  logic                  result_ready,
  output ssd_pkg::ctrl_cmd_t    cmd,
  input  ssd_pkg::ctrl_status_t status
);
  import ssd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_EMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    cmd.load_start = accept && (operation == OP_LOAD);
    cmd.tick       = accept && (operation == OP_TICK);
    cmd.split_step = (state == S_SPLIT);
    cmd.emit       = (state == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (operation == OP_LOAD) ? S_SPLIT : S_EMIT;
          end
        end
        S_SPLIT: begin
          if (status.split_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/ssd_datapath.sv
// Digit store, iterative divide-by-ten splitter, scan position and result
// register. Depends on ssd_pkg.
`timescale 1ns / 1ps
module ssd_datapath #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ssd_pkg::NUMBER_W-1:0] number,
  input  ssd_pkg::ctrl_cmd_t    cmd,
  output ssd_pkg::ctrl_status_t status,
  output ssd_pkg::result_t      result
);
  import ssd_pkg::*;

  localparam int          POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int          CNT_W = $clog2(DIGITS + 1);
  localparam logic [31:0] LIM   = max_value(DIGITS);
  localparam int          PROD_W = NUMBER_W + 16;

  logic [BCD_W-1:0]    digit_store [DIGITS];
  logic [CNT_W-1:0]    digit_count;
  logic [POS_W-1:0]    scan_position;
  logic [NUMBER_W-1:0] work;
  logic [POS_W-1:0]    step;
  logic [CNT_W-1:0]    cnt_work;

  logic [NUMBER_W-1:0] sat;
  logic [PROD_W-1:0]   prod;
  logic [NUMBER_W-1:0] quot;
  logic [NUMBER_W-1:0] quot_x10;
  logic [BCD_W-1:0]    rem;
  logic [CNT_W-1:0]    cnt_step;
  logic [CNT_W-1:0]    cnt_final;
  logic [POS_W-1:0]    pos_next;
  logic [CNT_W-1:0]    sel_bit;
  logic [ENABLE_W-1:0] enable;

  assign sat      = (32'(number) > LIM) ? LIM[NUMBER_W-1:0] : number;
  assign prod     = PROD_W'(work) * PROD_W'(RECIP_10);
  assign quot     = NUMBER_W'(prod >> RECIP_SHIFT);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = BCD_W'(work - quot_x10);
  assign cnt_step  = (work != '0) ? (CNT_W'(step) + CNT_W'(1)) : cnt_work;
  assign cnt_final = (cnt_step == '0) ? CNT_W'(1) : cnt_step;

  assign status.split_last = (step == POS_W'(DIGITS - 1));

  assign pos_next = (CNT_W'(scan_position) + CNT_W'(1) >= digit_count)
                    ? '0 : scan_position + POS_W'(1);

  assign sel_bit = digit_count - CNT_W'(1) - CNT_W'(scan_position);

  always_comb begin
    for (int k = 0; k < ENABLE_W; k++) begin
      enable[k] = (32'(sel_bit) == k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) begin
        digit_store[i] <= '0;
      end
      digit_count   <= CNT_W'(1);
      scan_position <= '0;
    end else begin
      if (cmd.tick) begin
        scan_position <= pos_next;
      end
      if (cmd.split_step) begin
        digit_store[step] <= rem;
        if (status.split_last) begin
          digit_count   <= cnt_final;
          scan_position <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      work     <= sat;
      step     <= '0;
      cnt_work <= '0;
    end else if (cmd.split_step) begin
      work     <= quot;
      step     <= step + POS_W'(1);
      cnt_work <= cnt_step;
    end
    if (cmd.emit) begin
      result.segments     <= seg_decode(digit_store[scan_position]);
      result.digit_enable <= enable;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (digit_count != '0) && (32'(digit_count) <= DIGITS))
    else $error("digit count out of range");

  a_pos_below_count: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(scan_position) < digit_count)
    else $error("scan position beyond significant digits");

  a_load_resets_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.split_step && status.split_last) |=> (scan_position == '0))
    else $error("scan not back at units after load");

  a_enable_onehot0: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> $onehot0(result.digit_enable))
    else $error("digit enable not one-hot");

endmodule

### hdl/seven_segment_scan_driver_top.sv
// Multiplexed seven-segment scan driver, top level. A tick word moves the
// controller to S_EMIT, which writes its result to the output register
// once that register is free; a load word runs the shared divide-by-ten
// step once per digit in S_SPLIT, then writes its result in S_EMIT. No new
// word is taken before that write, but a new word is taken while
// a finished result still waits in the output register. The units digit
// is enabled on bit (count-1), the leading digit on bit 0; zero shows one 0.
// Depends on ssd_pkg, ssd_controller and ssd_datapath.
`timescale 1ns / 1ps
module seven_segment_scan_driver_top #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  ssd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output ssd_pkg::result_t result
);
  import ssd_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  ssd_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (item.operation),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  ssd_datapath #(
    .DIGITS (DIGITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .number (item.number),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

### sim/ssd_display_check.sv
// Checker for the seven-segment scan driver: watches both channels, predicts
// the display word for every accepted input word and compares it on output.
// Depends on ssd_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps
module ssd_display_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  ssd_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  ssd_pkg::result_t result,
  output int               errors,
  output int               pending
);
  import ssd_pkg::*;

  localparam int          DIG       = DIGITS_DEFAULT;
  localparam int unsigned TOP_VALUE = 10 ** DIG - 1;
  localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic [BCD_W-1:0] shown_digits [DIG];
  int               shown_count;
  int               scan_idx;
  result_t          display_q [$];

  always @(posedge clk) begin
    result_t     want;
    result_t     got;
    int unsigned n;
    int          cnt;
    if (rst) begin
      foreach (shown_digits[i]) shown_digits[i] = '0;
      shown_count = 1;
      scan_idx    = 0;
      display_q.delete();
      errors      = 0;
      pending     = 0;
    end else begin
      // drain first: a word cannot leave in the cycle it arrives
      if (result_valid && result_ready) begin
        if (display_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected display word, expected none, actual %h", $time, result);
        end else begin
          got = display_q.pop_front();
          if (result.segments !== got.segments) begin
            errors++;
            $display("%0t: segments expected %h actual %h", $time, got.segments,
                     result.segments);
          end
          if (result.digit_enable !== got.digit_enable) begin
            errors++;
            $display("%0t: digit_enable expected %h actual %h", $time, got.digit_enable,
                     result.digit_enable);
          end
        end
      end
      if (item_valid && item_ready) begin
        if (item.operation == OP_LOAD) begin
          n   = item.number;
          cnt = 0;
          if (n > TOP_VALUE) n = TOP_VALUE;
          for (int i = 0; i < DIG; i++) begin
            shown_digits[i] = BCD_W'(n % 10);
            if (n != 0) cnt = i + 1;
            n = n / 10;
          end
          shown_count = (cnt == 0) ? 1 : cnt;
          scan_idx    = 0;
        end else begin
          scan_idx = (scan_idx + 1 >= shown_count) ? 0 : scan_idx + 1;
        end
        want.segments     = SEG_LUT[shown_digits[scan_idx]];
        want.digit_enable = ENABLE_W'(1 << (shown_count - 1 - scan_idx));
        display_q.push_back(want);
      end
      pending = display_q.size();
    end
  end

endmodule

### sim/tb.sv
// Testbench top for the seven-segment scan driver: drives load and tick words
// with random gaps and output stalls, and gives the verdict.
// Depends on ssd_pkg, seven_segment_scan_driver_top and ssd_display_check.
`timescale 1ns / 1ps
module tb;
  import ssd_pkg::*;

  localparam int WORDS     = 550;
  localparam int HOLD_AT   = 120;
  localparam int HOLD_LEN  = 300;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  int      errors;
  int      pending;
  bit      no_gaps      = 1'b0;
  int      sent         = 0;

  always #5 clk = ~clk;

  seven_segment_scan_driver_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  ssd_display_check i_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  task automatic send_word(input logic op, input logic [NUMBER_W-1:0] num);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    item.operation <= op;
    item.number    <= num;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_tick();
    send_word(OP_TICK, NUMBER_W'($urandom));
  endtask

  // number with a given count of significant digits; 5 means above range
  function automatic logic [NUMBER_W-1:0] pick_number(input int width);
    int unsigned lo;
    lo = 1;
    if (width == 0) return '0;
    if (width > 4) return NUMBER_W'($urandom_range(10000, 16383));
    repeat (width - 1) lo = lo * 10;
    return NUMBER_W'($urandom_range(lo, lo * 10 - 1));
  endfunction

  // receiver: random stall per word, one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge clk iff !rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (taken == HOLD_AT) stall = HOLD_LEN;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int ticks;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ticks before any load, zero, full range, saturation, gaps of zeros
    send_word(OP_TICK, '1);
    send_tick();
    send_word(OP_LOAD, '0);
    send_tick();
    send_word(OP_LOAD, 14'd9999);
    repeat (5) send_tick();
    send_word(OP_LOAD, '1);
    send_tick();
    send_word(OP_LOAD, 14'd10000);
    send_word(OP_LOAD, 14'd8192);
    send_tick();
    send_word(OP_LOAD, 14'd1);
    send_word(OP_LOAD, 14'd10);
    send_tick();
    send_word(OP_LOAD, 14'd1000);
    repeat (2) send_tick();
    send_word(OP_LOAD, 14'd9009);
    send_tick();

    while (sent < WORDS) begin
      no_gaps = (sent >= 300 && sent < 380);
      if ($urandom_range(0, 9) == 0) begin
        send_word(logic'($urandom), NUMBER_W'($urandom));
      end else begin
        send_word(OP_LOAD, pick_number($urandom_range(0, 5)));
        ticks = $urandom_range(0, 9);
        repeat (ticks) send_tick();
      end
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ssd_pkg.sv
hdl/ssd_controller.sv
hdl/ssd_datapath.sv
hdl/seven_segment_scan_driver_top.sv
sim/ssd_display_check.sv
sim/tb.sv
